/* rtl/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tbpf_pkg.sv */
`default_nettype none

package tbpf_pkg;

  localparam int VRAM_HALFWORDS_DEF = 32768;
  localparam int SCREEN_WIDTH_DEF   = 240;

  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_VRAM  = 2'd1;
  localparam logic [1:0] MODE_PAL   = 2'd2;

  localparam logic [1:0] CFG_BG_CONTROL   = 2'd0;
  localparam logic [1:0] CFG_H_SCROLL     = 2'd1;
  localparam logic [1:0] CFG_V_SCROLL     = 2'd2;
  localparam logic [1:0] CFG_LAYER_ENABLE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] address;
    logic [15:0] write_data;
    logic [7:0]  pixel_x;
    logic [7:0]  line_y;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        opaque;
  } out_item_t;

  typedef struct packed {
    logic [15:0] bg_control;
    logic [8:0]  h_scroll;
    logic [8:0]  v_scroll;
    logic        layer_enable;
  } layer_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCR,
    ST_CHR,
    ST_TEX,
    ST_OUT
  } fetch_state_t;

endpackage

`default_nettype wire

/* rtl/tiled_background_pixel_fetch.sv */
// Channel   Ports                               Direction  Moves
// in        in_valid, in_stall, in_item          input      one request item
// out       out_valid, out_stall, out_item       output     one pixel item
// cfg       cfg_we, cfg_index, cfg_wdata         input      one register write
//
// A write item leaves the sequencer idle. A pixel item passes the screen entry read, the
// dependent texel read and the palette read to the output register before the next item
// is taken; with the layer disabled it goes from the palette read straight to the output.
// Reset is synchronous, active low; it clears configuration, state and output valid, not data registers or memories.
// A stalled output holds the sequencer at its last step; input stalls meanwhile.
`default_nettype none

`include "assert_macros.svh"

module tiled_background_pixel_fetch
  import tbpf_pkg::*;
#(
  parameter int VRAM_HALFWORDS = VRAM_HALFWORDS_DEF,
  parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(VRAM_HALFWORDS);

  layer_cfg_t cfg_r;

  logic          vram_we;
  logic [AW-1:0] vram_waddr;
  logic [15:0]   vram_wdata;
  logic          vram_re;
  logic [AW-1:0] vram_raddr;
  logic [15:0]   vram_rdata;
  logic          pal_we;
  logic [7:0]    pal_waddr;
  logic [14:0]   pal_wdata;
  logic          pal_re;
  logic [7:0]    pal_raddr;
  logic [14:0]   pal_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BG_CONTROL: begin
          cfg_r.bg_control <= cfg_wdata;
        end
        CFG_H_SCROLL: begin
          cfg_r.h_scroll <= cfg_wdata[8:0];
        end
        CFG_V_SCROLL: begin
          cfg_r.v_scroll <= cfg_wdata[8:0];
        end
        CFG_LAYER_ENABLE: begin
          cfg_r.layer_enable <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  tbpf_ram #(
    .DEPTH (VRAM_HALFWORDS),
    .WIDTH (16)
  ) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (vram_re),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  tbpf_ram #(
    .DEPTH (256),
    .WIDTH (15)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  tbpf_fetch #(
    .VRAM_HALFWORDS (VRAM_HALFWORDS),
    .SCREEN_WIDTH   (SCREEN_WIDTH)
  ) u_fetch (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .vram_we    (vram_we),
    .vram_waddr (vram_waddr),
    .vram_wdata (vram_wdata),
    .vram_re    (vram_re),
    .vram_raddr (vram_raddr),
    .vram_rdata (vram_rdata),
    .pal_we     (pal_we),
    .pal_waddr  (pal_waddr),
    .pal_wdata  (pal_wdata),
    .pal_re     (pal_re),
    .pal_raddr  (pal_raddr),
    .pal_rdata  (pal_rdata)
  );

  `ASSERT_NOW(a_vram_port_excl, vram_we, !vram_re, "video memory written and read together")
  `ASSERT_NOW(a_vram_read_busy, vram_re, in_stall, "video memory read while taking items")
  `ASSERT_NEXT(a_pal_read_out, pal_re && rst_n, in_stall, "palette read not followed by output step")
  `ASSERT_NOW(a_out_from_fetch, $rose(out_valid), $past(in_stall), "result appeared without a fetch")

endmodule

`default_nettype wire

/* rtl/tbpf_ram.sv */
`default_nettype none

module tbpf_ram
  import tbpf_pkg::*;
#(
  parameter int DEPTH = VRAM_HALFWORDS_DEF,
  parameter int WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/tbpf_fetch.sv */
`default_nettype none

module tbpf_fetch
  import tbpf_pkg::*;
#(
  parameter int VRAM_HALFWORDS = VRAM_HALFWORDS_DEF,
  parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire layer_cfg_t                           cfg,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire in_item_t                             in_item,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output out_item_t                                 out_item,
  output logic                                      vram_we,
  output logic [$clog2(VRAM_HALFWORDS)-1:0]         vram_waddr,
  output logic [15:0]                               vram_wdata,
  output logic                                      vram_re,
  output logic [$clog2(VRAM_HALFWORDS)-1:0]         vram_raddr,
  input  wire logic [15:0]                          vram_rdata,
  output logic                                      pal_we,
  output logic [7:0]                                pal_waddr,
  output logic [14:0]                               pal_wdata,
  output logic                                      pal_re,
  output logic [7:0]                                pal_raddr,
  input  wire logic [14:0]                          pal_rdata
);

  localparam int AW         = $clog2(VRAM_HALFWORDS);
  localparam int ADDR_SPAN  = 65536;
  localparam int RED_STEPS  = $clog2((ADDR_SPAN + VRAM_HALFWORDS - 1) / VRAM_HALFWORDS);
  localparam logic [16:0] VRAM_SIZE    = 17'(VRAM_HALFWORDS);
  localparam logic [9:0]  SCREEN_LIMIT = 10'(SCREEN_WIDTH);

  // Reduce a 16-bit halfword address modulo the memory size.
  function automatic logic [AW-1:0] wrap_addr(input logic [15:0] raw);
    logic [16:0] v;
    v = {1'b0, raw};
    for (int j = RED_STEPS - 1; j >= 0; j--) begin
      if (v >= (VRAM_SIZE << j)) begin
        v = v - (VRAM_SIZE << j);
      end
    end
    return v[AW-1:0];
  endfunction

  function automatic logic [23:0] expand_colour(input logic [14:0] c);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    r = c[4:0];
    g = c[9:5];
    b = c[14:10];
    return {r, r[4:2], g, g[4:2], b, b[4:2]};
  endfunction

  fetch_state_t state_r;
  fetch_state_t state_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  out_item_t    out_item_r;

  logic [8:0]   px_r;
  logic [8:0]   py_r;
  logic [3:0]   bank_r;
  logic [1:0]   fx_r;
  logic         opaque_r;

  logic         in_acc;
  logic         is_pixel;
  logic         slot_free;
  logic         wide;
  logic         tall;
  logic [9:0]   px_sum;
  logic [9:0]   py_sum;
  logic [8:0]   px_nxt;
  logic [8:0]   py_nxt;
  logic [1:0]   block;
  logic [5:0]   scr_hi;
  logic [15:0]  screen_raw;
  logic [2:0]   fx3;
  logic [2:0]   fy3;
  logic [15:0]  char_raw;
  logic [15:0]  tex_shift;
  logic [3:0]   texel_idx;
  logic [16:0]  addr_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_pixel  = (in_item.mode == MODE_PIXEL) && ({2'b00, in_item.pixel_x} < SCREEN_LIMIT);
  assign slot_free = !out_valid_r || !out_stall;

  assign wide   = cfg.bg_control[14];
  assign tall   = cfg.bg_control[15];
  assign px_sum = 10'(in_item.pixel_x) + 10'(cfg.h_scroll);
  assign py_sum = 10'(in_item.line_y) + 10'(cfg.v_scroll);
  assign px_nxt = wide ? px_sum[8:0] : {1'b0, px_sum[7:0]};
  assign py_nxt = tall ? py_sum[8:0] : {1'b0, py_sum[7:0]};

  assign block      = wide ? {py_r[8], px_r[8]} : {1'b0, py_r[8]};
  assign scr_hi     = 6'(cfg.bg_control[12:8]) + 6'(block);
  assign screen_raw = {scr_hi, py_r[7:3], px_r[7:3]};

  assign fx3      = vram_rdata[10] ? ~px_r[2:0] : px_r[2:0];
  assign fy3      = vram_rdata[11] ? ~py_r[2:0] : py_r[2:0];
  assign char_raw = {1'b0, cfg.bg_control[3:2], 13'd0} + {2'b00, vram_rdata[9:0], 4'd0}
                    + {12'd0, fy3, fx3[2]};

  assign tex_shift = vram_rdata >> {fx_r, 2'b00};
  assign texel_idx = tex_shift[3:0];
  assign addr_ext  = 17'(in_item.address);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_pixel) begin
          state_nxt = cfg.layer_enable ? ST_SCR : ST_OUT;
        end
      end
      ST_SCR: begin
        state_nxt = ST_CHR;
      end
      ST_CHR: begin
        state_nxt = ST_TEX;
      end
      ST_TEX: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    vram_we    = 1'b0;
    vram_waddr = addr_ext[AW-1:0];
    vram_wdata = in_item.write_data;
    vram_re    = 1'b0;
    vram_raddr = wrap_addr(screen_raw);
    pal_we     = 1'b0;
    pal_waddr  = in_item.address[7:0];
    pal_wdata  = in_item.write_data[14:0];
    pal_re     = 1'b0;
    pal_raddr  = 8'd0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          vram_we = (in_item.mode == MODE_VRAM) && (addr_ext < VRAM_SIZE);
          pal_we  = (in_item.mode == MODE_PAL);
          pal_re  = is_pixel && !cfg.layer_enable;
        end
      end
      ST_SCR: begin
        vram_re = 1'b1;
      end
      ST_CHR: begin
        vram_re    = 1'b1;
        vram_raddr = wrap_addr(char_raw);
      end
      ST_TEX: begin
        pal_re    = 1'b1;
        pal_raddr = (texel_idx == 4'd0) ? 8'd0 : {bank_r, texel_idx};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == ST_OUT && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      opaque_r <= 1'b0;
    end
    if (state_r == ST_CHR) begin
      bank_r <= vram_rdata[15:12];
      fx_r   <= fx3[1:0];
    end
    if (state_r == ST_TEX) begin
      opaque_r <= (texel_idx != 4'd0);
    end
    if (state_r == ST_OUT && slot_free) begin
      out_item_r.pixel_rgb <= expand_colour(pal_rdata);
      out_item_r.opaque    <= opaque_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* sim/tiled_background_pixel_fetch_checker.sv */
`timescale 1ns / 100ps

module tiled_background_pixel_fetch_checker
  import tbpf_pkg::*;
#(
  parameter int VRAM_HALFWORDS = VRAM_HALFWORDS_DEF,
  parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  logic [15:0] vram_img [VRAM_HALFWORDS];
  logic [14:0] palette_img [256];
  layer_cfg_t  layer;
  out_item_t   pixel_q [$];
  out_item_t   want;
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [23:0] expand_rgb555(logic [14:0] c);
    return {c[4:0], c[4:2], c[9:5], c[9:7], c[14:10], c[14:12]};
  endfunction

  function automatic out_item_t fetch_pixel(logic [7:0] x, logic [7:0] y);
    int unsigned map_x, map_y, block_idx, entry_addr, texel_addr, tx, ty;
    logic [15:0] entry, texels;
    logic [3:0]  idx;
    out_item_t   res;
    res.pixel_rgb = expand_rgb555(palette_img[0]);
    res.opaque    = 1'b0;
    if (!layer.layer_enable) return res;
    map_x = (32'(x) + 32'(layer.h_scroll)) % (layer.bg_control[14] ? 512 : 256);
    map_y = (32'(y) + 32'(layer.v_scroll)) % (layer.bg_control[15] ? 512 : 256);
    block_idx = map_x / 256 + (map_y / 256) * (layer.bg_control[14] ? 2 : 1);
    entry_addr = 32'(layer.bg_control[12:8]) * 1024 + block_idx * 1024
                 + ((map_y / 8) % 32) * 32 + (map_x / 8) % 32;
    entry = vram_img[entry_addr % VRAM_HALFWORDS];
    tx = entry[10] ? 7 - map_x % 8 : map_x % 8;
    ty = entry[11] ? 7 - map_y % 8 : map_y % 8;
    texel_addr = 32'(layer.bg_control[3:2]) * 8192 + 32'(entry[9:0]) * 16 + ty * 2 + tx / 4;
    texels = vram_img[texel_addr % VRAM_HALFWORDS];
    idx = texels[4 * (tx % 4) +: 4];
    if (idx == 4'd0) return res;
    res.pixel_rgb = expand_rgb555(palette_img[{entry[15:12], idx}]);
    res.opaque    = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      layer = '0;
      pixel_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel item: pixel_rgb %06h opaque %0b",
                 out_item.pixel_rgb, out_item.opaque);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (out_item.pixel_rgb !== want.pixel_rgb) begin
            $error("pixel_rgb mismatch: expected %06h, actual %06h",
                   want.pixel_rgb, out_item.pixel_rgb);
            mismatches++;
          end
          if (out_item.opaque !== want.opaque) begin
            $error("opaque mismatch: expected %0b, actual %0b", want.opaque, out_item.opaque);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_item.mode)
          MODE_VRAM: begin
            if (in_item.address < VRAM_HALFWORDS) vram_img[in_item.address] = in_item.write_data;
          end
          MODE_PAL: begin
            palette_img[in_item.address[7:0]] = in_item.write_data[14:0];
          end
          MODE_PIXEL: begin
            if (in_item.pixel_x < SCREEN_WIDTH)
              pixel_q.push_back(fetch_pixel(in_item.pixel_x, in_item.line_y));
          end
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BG_CONTROL:   layer.bg_control   = cfg_wdata;
          CFG_H_SCROLL:     layer.h_scroll     = cfg_wdata[8:0];
          CFG_V_SCROLL:     layer.v_scroll     = cfg_wdata[8:0];
          CFG_LAYER_ENABLE: layer.layer_enable = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending <= pixel_q.size();
  end

endmodule

/* sim/tb_tiled_background_pixel_fetch.sv */
`timescale 1ns / 100ps

module tb_tiled_background_pixel_fetch;
  import tbpf_pkg::*;

  localparam int VRAM_HALFWORDS = VRAM_HALFWORDS_DEF;
  localparam int SCREEN_WIDTH   = SCREEN_WIDTH_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 163;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;

  layer_cfg_t  layer_now;
  logic [15:0] vram_mirror [VRAM_HALFWORDS];
  bit          vram_known [VRAM_HALFWORDS];
  bit          pal_known [256];
  int          src_gap_pct;
  int          sink_stall_pct;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          sent_total = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tiled_background_pixel_fetch uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tiled_background_pixel_fetch_checker fetch_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall, long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_total++;
  endtask

  task automatic drain(int unsigned extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apply_cfg(layer_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BG_CONTROL;
    cfg_wdata <= c.bg_control;
    @(posedge clk);
    cfg_index <= CFG_H_SCROLL;
    cfg_wdata <= {7'($urandom), c.h_scroll};
    @(posedge clk);
    cfg_index <= CFG_V_SCROLL;
    cfg_wdata <= {7'($urandom), c.v_scroll};
    @(posedge clk);
    cfg_index <= CFG_LAYER_ENABLE;
    cfg_wdata <= {15'($urandom), c.layer_enable};
    @(posedge clk);
    cfg_we    <= 1'b0;
    layer_now = c;
  endtask

  task automatic write_vram(logic [14:0] addr, logic [15:0] data);
    send_item('{MODE_VRAM, addr, data, 8'($urandom), 8'($urandom)});
    vram_mirror[addr] = data;
    vram_known[addr]  = 1'b1;
  endtask

  task automatic write_palette(logic [14:0] addr, logic [15:0] data);
    send_item('{MODE_PAL, addr, data, 8'($urandom), 8'($urandom)});
    pal_known[addr[7:0]] = 1'b1;
  endtask

  // fill in any unwritten map entry, texel halfword or non-backdrop palette colour the pixel would read
  task automatic prep_pixel(logic [7:0] x, logic [7:0] y);
    int unsigned px, py, sa, ca, fx, fy;
    logic        wide;
    logic [15:0] ent, tex;
    logic [3:0]  idx;
    if (!layer_now.layer_enable || x >= SCREEN_WIDTH) return;
    wide = layer_now.bg_control[14];
    px = (32'(x) + 32'(layer_now.h_scroll)) & (wide ? 32'd511 : 32'd255);
    py = (32'(y) + 32'(layer_now.v_scroll)) & (layer_now.bg_control[15] ? 32'd511 : 32'd255);
    sa = (32'(layer_now.bg_control[12:8]) * 1024
          + ((px >> 8) + (py >> 8) * (wide ? 2 : 1)) * 1024
          + ((py >> 3) & 31) * 32 + ((px >> 3) & 31)) % VRAM_HALFWORDS;
    if (!vram_known[sa]) write_vram(15'(sa), 16'($urandom));
    ent = vram_mirror[sa];
    fx = ent[10] ? 7 - (px & 7) : px & 7;
    fy = ent[11] ? 7 - (py & 7) : py & 7;
    ca = (32'(layer_now.bg_control[3:2]) * 8192 + 32'(ent[9:0]) * 16
          + fy * 2 + (fx >> 2)) % VRAM_HALFWORDS;
    if (!vram_known[ca]) write_vram(15'(ca), 16'($urandom));
    tex = vram_mirror[ca];
    idx = tex[4 * (fx & 3) +: 4];
    if (idx != 4'd0 && !pal_known[{ent[15:12], idx}])
      write_palette({7'($urandom), ent[15:12], idx}, 16'($urandom));
  endtask

  task automatic render_pixel(logic [7:0] x, logic [7:0] y);
    prep_pixel(x, y);
    send_item('{MODE_PIXEL, 15'($urandom), 16'($urandom), x, y});
  endtask

  task automatic random_step();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)
      render_pixel(8'($urandom_range(SCREEN_WIDTH - 1)), 8'($urandom_range(255)));
    else if (pick < 78)
      write_vram(15'($urandom), 16'($urandom));
    else if (pick < 85)
      write_palette(15'($urandom), 16'($urandom));
    else if (pick < 93)
      send_item('{MODE_PIXEL, 15'($urandom), 16'($urandom),
                  8'($urandom_range(255, SCREEN_WIDTH)), 8'($urandom)});
    else
      send_item('{MODE_UNUSED, 15'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)});
  endtask

  initial begin
    layer_cfg_t c;
    int         target;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BG_CONTROL;
    cfg_wdata      = '0;
    src_gap_pct    = 10;
    sink_stall_pct = 53;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // flipped tile in the top left corner, last bank, backdrop white
    apply_cfg('{16'h0000, 9'd0, 9'd0, 1'b1});
    write_palette(15'h7F00, 16'hFFFF);
    write_palette(15'h00FF, 16'h8001);
    write_vram(15'h0000, 16'hFFFF);
    write_vram(15'd16383, 16'hF00F);
    render_pixel(8'd0, 8'd0);
    render_pixel(8'd1, 8'd0);
    render_pixel(8'd3, 8'd0);
    send_item('{MODE_PIXEL, 15'h7FFF, 16'hFFFF, 8'(SCREEN_WIDTH), 8'd0});
    send_item('{MODE_PIXEL, 15'h0000, 16'h0000, 8'hFF, 8'hFF});
    send_item('{MODE_UNUSED, 15'h7FFF, 16'hFFFF, 8'hFF, 8'hFF});
    write_vram(15'h7FFF, 16'h0000);
    render_pixel(8'(SCREEN_WIDTH - 1), 8'hFF);
    drain(SETTLE_CYCLES);
    apply_cfg('{16'hFFFF, 9'd511, 9'd511, 1'b1});
    render_pixel(8'd0, 8'd0);
    render_pixel(8'(SCREEN_WIDTH - 1), 8'd159);
    drain(SETTLE_CYCLES);
    apply_cfg('{16'h5A3C, 9'd37, 9'd200, 1'b0});
    render_pixel(8'd100, 8'd50);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < PHASES / 3) begin
        src_gap_pct    = 10;
        sink_stall_pct = 53;
      end else if (ph < 2 * PHASES / 3) begin
        src_gap_pct    = 53;
        sink_stall_pct = 10;
      end else begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      drain(SETTLE_CYCLES);
      c = '{16'($urandom), 9'($urandom), 9'($urandom), ($urandom_range(5) != 0)};
      case (ph)
        0: c = '{16'h0000, 9'd0, 9'd0, 1'b1};
        1: c = '{16'hFFFF, 9'd511, 9'd511, 1'b1};
        2: c.layer_enable = 1'b0;
        default: ;
      endcase
      apply_cfg(c);
      if (ph == 2 * PHASES / 3) hold_requests++;
      target = sent_total + PHASE_ITEMS;
      while (sent_total < target) begin
        // hold back until every pixel is out
        if (ph == 2 * PHASES / 3 + 1 && target - sent_total == PHASE_ITEMS / 2) drain(0);
        random_step();
      end
    end

    drain(SETTLE_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tbpf_pkg.sv
rtl/tbpf_ram.sv
rtl/tbpf_fetch.sv
rtl/tiled_background_pixel_fetch.sv
sim/tiled_background_pixel_fetch_checker.sv
sim/tb_tiled_background_pixel_fetch.sv
